// ===== design/gyro_accel_angle_kalman_unit_macros.svh =====
// ----------------------------------------------------------------------------
// gyro_accel_angle_kalman_unit assertion macros
// Concurrent check wrappers, clocked on clk and disabled during arst_n reset.
// ----------------------------------------------------------------------------
`ifndef GYRO_ACCEL_ANGLE_KALMAN_UNIT_MACROS_SVH
`define GYRO_ACCEL_ANGLE_KALMAN_UNIT_MACROS_SVH

`ifndef SYNTH
// property that must hold at every clock edge
`define GAK_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("gak check failed");
// consequent must hold in the cycle after the antecedent
`define GAK_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gak check failed");
`else
`define GAK_ASSERT(lbl, prop)
`define GAK_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/gak_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gak_pkg
// Shared types, constants and saturation helpers for the angle Kalman filter.
// ----------------------------------------------------------------------------
package gak_pkg;

	// default fixed point format
	localparam int FRAC_BITS_DEF = 16;

	// configuration register indexes
	localparam logic [1:0] CFG_ANGLE_NOISE = 2'd0;
	localparam logic [1:0] CFG_BIAS_NOISE  = 2'd1;
	localparam logic [1:0] CFG_MEAS_NOISE  = 2'd2;

	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RATE,
		ST_MDT,
		ST_ANG,
		ST_T1,
		ST_T2,
		ST_T3,
		ST_MT,
		ST_P00,
		ST_P01,
		ST_P10,
		ST_P11,
		ST_SUM,
		ST_DIV0,
		ST_WAIT0,
		ST_DIV1,
		ST_WAIT1,
		ST_ERR,
		ST_MKE,
		ST_ANG2,
		ST_BIAS,
		ST_C00,
		ST_C01,
		ST_C10,
		ST_C11,
		ST_DONE
	} gak_state_t;

	// divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} gak_div_stat_t;

	// clamp an exact 33-bit sum to the 32-bit signed range
	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] != v[31])
			return v[32] ? S32_MIN : S32_MAX;
		return v[31:0];
	endfunction

	// clamp a 64-bit value to the 32-bit signed range
	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		if ((v[63:31] != '0) && (v[63:31] != '1))
			return v[63] ? S32_MIN : S32_MAX;
		return v[31:0];
	endfunction

endpackage

// ===== design/gak_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gak_div
// Radix-2 restoring divider for the gain terms: (num << FRAC_BITS) / den,
// truncated toward zero and clamped to 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gak_div #(
	parameter int FRAC_BITS = gak_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [31:0]    num,
	input  logic signed [31:0]    den,
	output gak_pkg::gak_div_stat_t stat,
	output logic signed [31:0]    quo
);
	import gak_pkg::*;

	localparam int DW = 32 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] dq_q;
	logic [31:0]   rem_q;
	logic [31:0]   dmag_q;
	logic          neg_q;

	logic [31:0] num_mag;
	logic [31:0] den_mag;
	logic [32:0] rs;
	logic [32:0] rs_sub;
	logic        ge;

	// magnitudes of the operands
	assign num_mag = num[31] ? 32'(-num) : num;
	assign den_mag = den[31] ? 32'(-den) : den;

	// one restoring step
	assign rs     = {rem_q, dq_q[DW-1]};
	assign ge     = rs >= {1'b0, dmag_q};
	assign rs_sub = rs - {1'b0, dmag_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dq_q   <= {num_mag, FRAC_BITS'(0)};
			rem_q  <= '0;
			dmag_q <= den_mag;
			neg_q  <= num[31] ^ den[31];
		end else if (busy_q) begin
			dq_q  <= {dq_q[DW-2:0], ge};
			rem_q <= ge ? rs_sub[31:0] : rs[31:0];
		end
	end

	// sign and clamp of the finished quotient
	always_comb begin
		if (neg_q) begin
			if (dq_q[DW-1:31] != '0)
				quo = S32_MIN;
			else
				quo = 32'(-signed'({1'b0, dq_q[30:0]}));
		end else begin
			if (dq_q[DW-1:31] != '0)
				quo = S32_MAX;
			else
				quo = signed'({1'b0, dq_q[30:0]});
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== design/gyro_accel_angle_kalman_unit.sv =====
`timescale 1ns / 1ps
// Q16.16 by default (FRAC_BITS); one item at a time: in_stall stays high from the
// input beat until the result is registered, and a zero gain divisor skips both
// divisions. The two radix-2 gain divisions dominate; every other step runs on a
// shared 32x32 multiplier or saturating adder.
// Reset clears the estimates and covariance and loads the default noise values.
// ----------------------------------------------------------------------------
// gyro_accel_angle_kalman_unit
// Two-state angle/gyro-bias Kalman filter, signed fixed point with saturation,
// run by a small sequencer over one multiplier, one adder and one divider.
// ----------------------------------------------------------------------------
module gyro_accel_angle_kalman_unit #(
	parameter int FRAC_BITS = gak_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_wdata,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] accel_angle,
	input  logic signed [31:0] gyro_rate,
	input  logic [16:0]        time_step,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] fused_angle,
	output logic               zero_divisor
);
	import gak_pkg::*;

	`include "gyro_accel_angle_kalman_unit_macros.svh"

	localparam longint Q_ONE = 64'sd1 <<< FRAC_BITS;
	localparam logic [30:0] RST_ANGLE_NOISE = 31'((2 * Q_ONE + 50) / 100);
	localparam logic [30:0] RST_BIAS_NOISE  = 31'((3 * Q_ONE + 500) / 1000);
	localparam logic [30:0] RST_MEAS_NOISE  = 31'((3 * Q_ONE + 50) / 100);
	localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

	gak_state_t state_q, state_d;

	// configuration
	logic [30:0] angle_noise_q;
	logic [30:0] bias_noise_q;
	logic [30:0] meas_noise_q;

	// filter state
	logic signed [31:0] ang_q, bias_q;
	logic signed [31:0] p00_q, p01_q, p10_q, p11_q;

	// per-item working registers
	logic signed [31:0] accel_q, gyro_q;
	logic [16:0]        dt_q;
	logic signed [31:0] rate_q, t_q, dp_q, s_q, k0_q, k1_q, err_q;
	logic signed [31:0] p00o_q, p01o_q;
	logic               zero_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] fused_q;
	logic               zdiv_q;

	// shared units
	logic               mul_en;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_c, prod_q, prod_rnd;
	logic signed [31:0] mr;
	logic signed [31:0] add_a, add_b;
	logic               add_neg;
	logic signed [32:0] add_sum;
	logic signed [31:0] add_res;
	logic               div_start;
	logic signed [31:0] div_num;
	logic signed [31:0] div_quo;
	gak_div_stat_t      div_stat;

	logic signed [31:0] dt_s;
	logic               out_free;

	assign dt_s     = signed'({15'd0, dt_q});
	assign out_free = !out_valid_q || !out_stall;

	// multiplier with registered product, then round and clamp
	assign prod_c   = mul_a * mul_b;
	assign prod_rnd = prod_q + RND_HALF;
	assign mr       = sat64(prod_rnd >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= prod_c;
	end

	// saturating adder
	assign add_sum = add_neg ? ({add_a[31], add_a} - {add_b[31], add_b})
	                         : ({add_a[31], add_a} + {add_b[31], add_b});
	assign add_res = sat33(add_sum);

	// gain divider
	gak_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (s_q),
		.stat  (div_stat),
		.quo   (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_RATE;
			ST_RATE:  state_d = ST_MDT;
			ST_MDT:   state_d = ST_ANG;
			ST_ANG:   state_d = ST_T1;
			ST_T1:    state_d = ST_T2;
			ST_T2:    state_d = ST_T3;
			ST_T3:    state_d = ST_MT;
			ST_MT:    state_d = ST_P00;
			ST_P00:   state_d = ST_P01;
			ST_P01:   state_d = ST_P10;
			ST_P10:   state_d = ST_P11;
			ST_P11:   state_d = ST_SUM;
			ST_SUM:   state_d = (add_res == '0) ? ST_ERR : ST_DIV0;
			ST_DIV0:  state_d = ST_WAIT0;
			ST_WAIT0: if (div_stat.done) state_d = ST_DIV1;
			ST_DIV1:  state_d = ST_WAIT1;
			ST_WAIT1: if (div_stat.done) state_d = ST_ERR;
			ST_ERR:   state_d = ST_MKE;
			ST_MKE:   state_d = ST_ANG2;
			ST_ANG2:  state_d = ST_BIAS;
			ST_BIAS:  state_d = ST_C00;
			ST_C00:   state_d = ST_C01;
			ST_C01:   state_d = ST_C10;
			ST_C10:   state_d = ST_C11;
			ST_C11:   state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// unit operand selection per step
	always_comb begin
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		add_a     = '0;
		add_b     = '0;
		add_neg   = 1'b0;
		div_start = 1'b0;
		div_num   = '0;
		case (state_q)
			ST_RATE: begin
				add_a   = gyro_q;
				add_b   = bias_q;
				add_neg = 1'b1;
			end
			ST_MDT: begin
				mul_en = 1'b1;
				mul_a  = dt_s;
				mul_b  = rate_q;
			end
			ST_ANG: begin
				add_a  = ang_q;
				add_b  = mr;
				mul_en = 1'b1;
				mul_a  = dt_s;
				mul_b  = p11_q;
			end
			ST_T1: begin
				add_a   = mr;
				add_b   = p01_q;
				add_neg = 1'b1;
			end
			ST_T2: begin
				add_a   = t_q;
				add_b   = p10_q;
				add_neg = 1'b1;
			end
			ST_T3: begin
				add_a = t_q;
				add_b = signed'({1'b0, angle_noise_q});
			end
			ST_MT: begin
				mul_en = 1'b1;
				mul_a  = dt_s;
				mul_b  = t_q;
			end
			ST_P00: begin
				add_a  = p00_q;
				add_b  = mr;
				mul_en = 1'b1;
				mul_a  = signed'({1'b0, bias_noise_q});
				mul_b  = dt_s;
			end
			ST_P01: begin
				add_a   = p01_q;
				add_b   = dp_q;
				add_neg = 1'b1;
			end
			ST_P10: begin
				add_a   = p10_q;
				add_b   = dp_q;
				add_neg = 1'b1;
			end
			ST_P11: begin
				add_a = p11_q;
				add_b = mr;
			end
			ST_SUM: begin
				add_a = p00_q;
				add_b = signed'({1'b0, meas_noise_q});
			end
			ST_DIV0: begin
				div_start = 1'b1;
				div_num   = p00_q;
			end
			ST_DIV1: begin
				div_start = 1'b1;
				div_num   = p10_q;
			end
			ST_ERR: begin
				add_a   = accel_q;
				add_b   = ang_q;
				add_neg = 1'b1;
			end
			ST_MKE: begin
				mul_en = 1'b1;
				mul_a  = k0_q;
				mul_b  = err_q;
			end
			ST_ANG2: begin
				add_a  = ang_q;
				add_b  = mr;
				mul_en = 1'b1;
				mul_a  = k1_q;
				mul_b  = err_q;
			end
			ST_BIAS: begin
				add_a  = bias_q;
				add_b  = mr;
				mul_en = 1'b1;
				mul_a  = k0_q;
				mul_b  = p00o_q;
			end
			ST_C00: begin
				add_a   = p00_q;
				add_b   = mr;
				add_neg = 1'b1;
				mul_en  = 1'b1;
				mul_a   = k0_q;
				mul_b   = p01o_q;
			end
			ST_C01: begin
				add_a   = p01_q;
				add_b   = mr;
				add_neg = 1'b1;
				mul_en  = 1'b1;
				mul_a   = k1_q;
				mul_b   = p00o_q;
			end
			ST_C10: begin
				add_a   = p10_q;
				add_b   = mr;
				add_neg = 1'b1;
				mul_en  = 1'b1;
				mul_a   = k1_q;
				mul_b   = p01o_q;
			end
			ST_C11: begin
				add_a   = p11_q;
				add_b   = mr;
				add_neg = 1'b1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// sequencer, configuration, filter state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			angle_noise_q <= RST_ANGLE_NOISE;
			bias_noise_q  <= RST_BIAS_NOISE;
			meas_noise_q  <= RST_MEAS_NOISE;
			ang_q         <= '0;
			bias_q        <= '0;
			p00_q         <= '0;
			p01_q         <= '0;
			p10_q         <= '0;
			p11_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			// register writes, indexes past the list are dropped
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_ANGLE_NOISE: angle_noise_q <= cfg_wdata;
					CFG_BIAS_NOISE:  bias_noise_q  <= cfg_wdata;
					CFG_MEAS_NOISE:  meas_noise_q  <= cfg_wdata;
					default:         ;
				endcase
			end

			// estimate and covariance updates
			case (state_q)
				ST_ANG:  ang_q  <= add_res;
				ST_P00:  p00_q  <= add_res;
				ST_P01:  p01_q  <= add_res;
				ST_P10:  p10_q  <= add_res;
				ST_P11:  p11_q  <= add_res;
				ST_ANG2: ang_q  <= add_res;
				ST_BIAS: bias_q <= add_res;
				ST_C00:  p00_q  <= add_res;
				ST_C01:  p01_q  <= add_res;
				ST_C10:  p10_q  <= add_res;
				ST_C11:  p11_q  <= add_res;
				default: ;
			endcase

			// result beat
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					accel_q <= accel_angle;
					gyro_q  <= gyro_rate;
					dt_q    <= time_step;
				end
			end
			ST_RATE: rate_q <= add_res;
			ST_T1: begin
				t_q  <= add_res;
				dp_q <= mr;
			end
			ST_T2: t_q <= add_res;
			ST_T3: t_q <= add_res;
			ST_SUM: begin
				s_q    <= add_res;
				zero_q <= (add_res == '0);
				k0_q   <= '0;
				k1_q   <= '0;
			end
			ST_WAIT0: if (div_stat.done) k0_q <= div_quo;
			ST_WAIT1: if (div_stat.done) k1_q <= div_quo;
			ST_ERR: begin
				err_q  <= add_res;
				p00o_q <= p00_q;
				p01o_q <= p01_q;
			end
			ST_DONE: begin
				if (out_free) begin
					fused_q <= ang_q;
					zdiv_q  <= zero_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign fused_angle  = fused_q;
	assign zero_divisor = zdiv_q;

	// checks
	`GAK_ASSERT(a_div_busy_in_wait, !div_stat.busy || state_q == ST_WAIT0 || state_q == ST_WAIT1)
	`GAK_ASSERT(a_zero_gains, !(state_q == ST_ERR && zero_q) || (k0_q == '0 && k1_q == '0))
	`GAK_ASSERT_NEXT(a_beat_from_done, !out_valid_q, !out_valid_q || $past(state_q) == ST_DONE)

endmodule
